// ----- src/teru_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trap entry and return unit package
// Types, codes and constants shared by the trap entry and return unit.
// ----------------------------------------------------------------------------
package teru_pkg;

   localparam int GATE_COUNT_DEFAULT = 256;

   localparam int IF_BIT = 9;
   localparam logic [7:0] SYSCALL_FRAME_VECTOR = 8'h80;

   // Actions
   localparam logic [2:0] ACT_EXCEPTION    = 3'd0;
   localparam logic [2:0] ACT_INTERRUPT    = 3'd1;
   localparam logic [2:0] ACT_SOFT_INT     = 3'd2;
   localparam logic [2:0] ACT_SYSCALL      = 3'd3;
   localparam logic [2:0] ACT_TRAP_RETURN  = 3'd4;
   localparam logic [2:0] ACT_SYSCALL_RET  = 3'd5;
   localparam logic [2:0] ACT_GATE_WRITE   = 3'd6;

   // Frame kinds
   localparam logic [1:0] KIND_SYSCALL = 2'd3;

   // Status codes
   localparam logic [2:0] STS_OK               = 3'd0;
   localparam logic [2:0] STS_SYSCALL_DISABLED = 3'd1;
   localparam logic [2:0] STS_NO_PENDING       = 3'd2;
   localparam logic [2:0] STS_PENDING_NOT_SYS  = 3'd3;
   localparam logic [2:0] STS_NO_RING_STACK    = 3'd4;
   localparam logic [2:0] STS_GATE_ABSENT      = 3'd5;

   // Configuration register indexes
   localparam logic [2:0] CSR_SYSCALL_ENABLE = 3'd0;
   localparam logic [2:0] CSR_SYSCALL_ENTRY  = 3'd1;
   localparam logic [2:0] CSR_SYSCALL_MASK   = 3'd2;
   localparam logic [2:0] CSR_STACK_PRESENT  = 3'd3;
   localparam logic [2:0] CSR_RING0_STACK    = 3'd4;
   localparam logic [2:0] CSR_RING1_STACK    = 3'd5;
   localparam logic [2:0] CSR_RING2_STACK    = 3'd6;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  vector;
      logic        has_err_code;
      logic [63:0] err_code;
      logic [63:0] current_rip;
      logic [63:0] target_address;
      logic [63:0] flags_in;
      logic [63:0] stack_in;
      logic [1:0]  level_in;
      logic [63:0] rcx_in;
      logic [63:0] r11_in;
      logic [3:0]  gate_attr;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] new_rip;
      logic [63:0] new_flags;
      logic [63:0] new_stack;
      logic [1:0]  new_level;
      logic        link_write;
      logic [63:0] rcx_out;
      logic [63:0] r11_out;
      logic [1:0]  frame_kind;
      logic [7:0]  frame_vector;
      logic        frame_has_error;
      logic [63:0] frame_err_code;
   } rsp_type;

endpackage

// ----- src/trap_entry_return_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trap entry and return unit
// Gate lookup, ring and stack switch, pending frame save and restore.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_payload (teru_pkg::req_type)
//   rsp      out        rsp_valid/rsp_ready    rsp_payload (teru_pkg::rsp_type)
//   csr      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// For each item, the transfer cycle issues the gate memory read, and the
// evaluation state then evaluates the action and loads the result register.
// A new request is taken only once the previous one has left the evaluation
// cycle; the result register lets it be taken while a result still waits.
// Reset clears the gate present bits and the pending frame; no clearing pass.
// A stalled result holds the unit in the evaluation cycle; csr is always ready.
// ----------------------------------------------------------------------------
module trap_entry_return_unit #(
   parameter int GATE_COUNT = teru_pkg::GATE_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  teru_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output teru_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_wdata
);

   localparam int IDX_W = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;

   // Configuration registers
   logic        sys_enable_ff;
   logic [63:0] sys_entry_ff;
   logic [63:0] sys_mask_ff;
   logic [2:0]  stack_present_ff;
   logic [63:0] ring0_stack_ff;
   logic [63:0] ring1_stack_ff;
   logic [63:0] ring2_stack_ff;

   // Pending frame
   logic        pend_valid_ff, pend_valid_in;
   logic [1:0]  pend_kind_ff, pend_kind_in;
   logic [63:0] pend_return_ff, pend_return_in;
   logic [63:0] pend_flags_ff, pend_flags_in;
   logic [63:0] pend_stack_ff, pend_stack_in;
   logic [1:0]  pend_level_ff, pend_level_in;

   // Gate table: attribute and handler in one memory, present bits in flops
   logic [67:0]           gate_mem_ff [GATE_COUNT];
   logic [67:0]           gate_rd_ff;
   logic [GATE_COUNT-1:0] gate_valid_ff;
   logic                  gate_hit_ff;

   teru_pkg::state_type state_ff, state_in;
   teru_pkg::req_type   req_ff;
   teru_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff;

   logic req_fire;
   logic commit;
   logic gate_we;
   logic req_in_range;
   logic cur_in_range;
   logic [IDX_W-1:0] req_idx;
   logic [IDX_W-1:0] cur_idx;

   logic [3:0]  eff_attr;
   logic [1:0]  tlvl;
   logic [63:0] ring_stack;

   assign csr_ready   = 1'b1;
   assign req_fire    = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign req_idx      = req_payload.vector[IDX_W-1:0];
   assign cur_idx      = req_ff.vector[IDX_W-1:0];
   assign req_in_range = 32'(req_payload.vector) < GATE_COUNT;
   assign cur_in_range = 32'(req_ff.vector) < GATE_COUNT;

   // State machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= teru_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         teru_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = teru_pkg::ST_EXEC;
            end
         end
         teru_pkg::ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               commit   = 1'b1;
               state_in = teru_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = teru_pkg::ST_IDLE;
         end
      endcase
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sys_enable_ff    <= 1'b0;
         sys_entry_ff     <= '0;
         sys_mask_ff      <= '0;
         stack_present_ff <= '0;
         ring0_stack_ff   <= '0;
         ring1_stack_ff   <= '0;
         ring2_stack_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            teru_pkg::CSR_SYSCALL_ENABLE: sys_enable_ff    <= csr_wdata[0];
            teru_pkg::CSR_SYSCALL_ENTRY:  sys_entry_ff     <= csr_wdata;
            teru_pkg::CSR_SYSCALL_MASK:   sys_mask_ff      <= csr_wdata;
            teru_pkg::CSR_STACK_PRESENT:  stack_present_ff <= csr_wdata[2:0];
            teru_pkg::CSR_RING0_STACK:    ring0_stack_ff   <= csr_wdata;
            teru_pkg::CSR_RING1_STACK:    ring1_stack_ff   <= csr_wdata;
            teru_pkg::CSR_RING2_STACK:    ring2_stack_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Request capture and gate memory read
   assign gate_we = commit && (req_ff.action == teru_pkg::ACT_GATE_WRITE) && cur_in_range;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff     <= req_payload;
         gate_rd_ff <= gate_mem_ff[req_idx];
      end
      if (gate_we) begin
         gate_mem_ff[cur_idx] <= {req_ff.gate_attr, req_ff.target_address};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_valid_ff <= '0;
         gate_hit_ff   <= 1'b0;
      end else begin
         if (req_fire) begin
            gate_hit_ff <= req_in_range && gate_valid_ff[req_idx];
         end
         if (gate_we) begin
            gate_valid_ff[cur_idx] <= 1'b1;
         end
      end
   end

   // Action evaluation
   assign eff_attr = gate_hit_ff ? gate_rd_ff[67:64] : 4'd0;
   assign tlvl     = eff_attr[3:2];

   always_comb begin
      case (tlvl)
         2'd0:    ring_stack = ring0_stack_ff;
         2'd1:    ring_stack = ring1_stack_ff;
         default: ring_stack = ring2_stack_ff;
      endcase
   end

   always_comb begin
      rsp_in           = '0;
      rsp_in.status    = teru_pkg::STS_OK;
      rsp_in.new_rip   = req_ff.current_rip;
      rsp_in.new_flags = req_ff.flags_in;
      rsp_in.new_stack = req_ff.stack_in;
      rsp_in.new_level = req_ff.level_in;

      pend_valid_in  = pend_valid_ff;
      pend_kind_in   = pend_kind_ff;
      pend_return_in = pend_return_ff;
      pend_flags_in  = pend_flags_ff;
      pend_stack_in  = pend_stack_ff;
      pend_level_in  = pend_level_ff;

      case (req_ff.action)
         teru_pkg::ACT_EXCEPTION, teru_pkg::ACT_INTERRUPT, teru_pkg::ACT_SOFT_INT: begin
            if (!eff_attr[0]) begin
               rsp_in.status = teru_pkg::STS_GATE_ABSENT;
            end else if ((tlvl < req_ff.level_in)
                         && (!stack_present_ff[tlvl] || tlvl == 2'd3)) begin
               rsp_in.status = teru_pkg::STS_NO_RING_STACK;
            end else begin
               pend_valid_in  = 1'b1;
               pend_kind_in   = req_ff.action[1:0];
               pend_return_in = (req_ff.action == teru_pkg::ACT_SOFT_INT)
                                ? req_ff.target_address : req_ff.current_rip;
               pend_flags_in  = req_ff.flags_in;
               pend_stack_in  = req_ff.stack_in;
               pend_level_in  = req_ff.level_in;

               rsp_in.new_rip = gate_rd_ff[63:0];
               if (eff_attr[1]) begin
                  rsp_in.new_flags[teru_pkg::IF_BIT] = 1'b0;
               end
               if (tlvl < req_ff.level_in) begin
                  rsp_in.new_stack = ring_stack;
               end
               rsp_in.new_level    = tlvl;
               rsp_in.frame_kind   = req_ff.action[1:0];
               rsp_in.frame_vector = req_ff.vector;
               if (req_ff.action == teru_pkg::ACT_EXCEPTION && req_ff.has_err_code) begin
                  rsp_in.frame_has_error = 1'b1;
                  rsp_in.frame_err_code  = req_ff.err_code;
               end
            end
         end
         teru_pkg::ACT_SYSCALL: begin
            if (!sys_enable_ff) begin
               rsp_in.status = teru_pkg::STS_SYSCALL_DISABLED;
            end else begin
               pend_valid_in  = 1'b1;
               pend_kind_in   = teru_pkg::KIND_SYSCALL;
               pend_return_in = req_ff.target_address;
               pend_flags_in  = req_ff.flags_in;
               pend_stack_in  = req_ff.stack_in;
               pend_level_in  = req_ff.level_in;

               rsp_in.new_rip      = sys_entry_ff;
               rsp_in.new_flags    = req_ff.flags_in & ~sys_mask_ff;
               rsp_in.new_stack    = stack_present_ff[0] ? ring0_stack_ff : req_ff.stack_in;
               rsp_in.new_level    = 2'd0;
               rsp_in.link_write   = 1'b1;
               rsp_in.rcx_out      = req_ff.target_address;
               rsp_in.r11_out      = req_ff.flags_in;
               rsp_in.frame_kind   = teru_pkg::KIND_SYSCALL;
               rsp_in.frame_vector = teru_pkg::SYSCALL_FRAME_VECTOR;
            end
         end
         teru_pkg::ACT_TRAP_RETURN: begin
            if (!pend_valid_ff) begin
               rsp_in.status = teru_pkg::STS_NO_PENDING;
            end else begin
               rsp_in.new_rip   = pend_return_ff;
               rsp_in.new_flags = pend_flags_ff;
               rsp_in.new_stack = pend_stack_ff;
               rsp_in.new_level = pend_level_ff;
               pend_valid_in    = 1'b0;
            end
         end
         teru_pkg::ACT_SYSCALL_RET: begin
            if (!pend_valid_ff || pend_kind_ff != teru_pkg::KIND_SYSCALL) begin
               rsp_in.status = teru_pkg::STS_PENDING_NOT_SYS;
            end else begin
               rsp_in.new_rip   = req_ff.rcx_in;
               rsp_in.new_flags = req_ff.r11_in;
               rsp_in.new_stack = pend_stack_ff;
               rsp_in.new_level = pend_level_ff;
               pend_valid_in    = 1'b0;
            end
         end
         default: begin
            // Gate writes and the unused action code only echo the state.
         end
      endcase
   end

   // Pending frame and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff  <= 1'b0;
         pend_kind_ff   <= '0;
         pend_return_ff <= '0;
         pend_flags_ff  <= '0;
         pend_stack_ff  <= '0;
         pend_level_ff  <= '0;
      end else if (commit) begin
         pend_valid_ff  <= pend_valid_in;
         pend_kind_ff   <= pend_kind_in;
         pend_return_ff <= pend_return_in;
         pend_flags_ff  <= pend_flags_in;
         pend_stack_ff  <= pend_stack_in;
         pend_level_ff  <= pend_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
